// ===== src/frq_pkg.sv =====
// ----------------------------------------------------------------------------
// frq_pkg
// Shared types and constants for the feedback priority ready queue.
// ----------------------------------------------------------------------------
package frq_pkg;

  localparam int TID_W    = 6;
  localparam int PRIO_W   = 2;
  localparam int USED_W   = 16;
  localparam int LEVELS   = 3;
  localparam int LV_W     = 2;
  localparam int ID_SPAN  = 1 << TID_W;

  localparam logic [PRIO_W-1:0] PRIO_LOW  = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_MED  = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_HIGH = 2'd2;

  localparam logic [USED_W-1:0] QUANTUM_RESET = 16'd10;

  localparam int                APB_ADDR_W  = 3;
  localparam logic              REG_QUANTUM = 1'b0;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_ENQUEUE = 2'd1,
    CMD_DEQUEUE = 2'd2,
    CMD_ADJUST  = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [TID_W-1:0]  thread_id;
    logic [PRIO_W-1:0] priority_level;
    logic [USED_W-1:0] time_used;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0]  result_thread;
    logic [PRIO_W-1:0] result_priority;
    logic [PRIO_W-1:0] previous_priority;
    logic              changed;
    logic              status;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic commit;
  } ctrl_t;

  typedef struct packed {
    logic rsp_valid;
  } stat_t;

endpackage

// ===== src/frq_if.sv =====
// ----------------------------------------------------------------------------
// frq_req_if / frq_rsp_if
// Valid/ready channels carrying command and result transactions.
// ----------------------------------------------------------------------------
interface frq_req_if;
  logic          valid;
  logic          ready;
  frq_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface frq_rsp_if;
  logic          valid;
  logic          ready;
  frq_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/frq_ram.sv =====
// ----------------------------------------------------------------------------
// frq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module frq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/frq_ctrl.sv =====
// ----------------------------------------------------------------------------
// frq_ctrl
// Command sequencer: read cycle, then execute and write-back cycle.
// ----------------------------------------------------------------------------
module frq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  logic          rsp_ready_i,
  input  frq_pkg::stat_t stat_i,
  output frq_pkg::ctrl_t ctrl_o
);
  import frq_pkg::*;

  state_e state_q, state_d;
  logic   slot_free;

  assign slot_free = !stat_i.rsp_valid || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    ctrl_o.load   = 1'b0;
    ctrl_o.commit = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        ctrl_o.load = req_valid_i;
      end
      ST_EXEC: begin
        ctrl_o.commit = slot_free;
      end
      default: begin
        req_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/frq_datapath.sv =====
// ----------------------------------------------------------------------------
// frq_datapath
// Priority and link memories, per-level head/tail state and result register.
// ----------------------------------------------------------------------------
module frq_datapath #(
  parameter int MAX_THREADS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  frq_pkg::ctrl_t                ctrl_i,
  input  frq_pkg::req_t                 req_i,
  input  logic [frq_pkg::USED_W-1:0]    quantum_i,
  input  logic                          rsp_ready_i,
  output frq_pkg::rsp_t                 rsp_o,
  output frq_pkg::stat_t                stat_o
);
  import frq_pkg::*;

  localparam int Depth = (MAX_THREADS < ID_SPAN) ? MAX_THREADS : ID_SPAN;
  localparam int IdxW  = $clog2(Depth);

  cmd_e              cmd_q;
  logic [TID_W-1:0]  tid_q;
  logic [PRIO_W-1:0] plev_q;
  logic [USED_W-1:0] used_q;

  logic [IdxW-1:0]   head_q [LEVELS];
  logic [IdxW-1:0]   head_d [LEVELS];
  logic [IdxW-1:0]   tail_q [LEVELS];
  logic [IdxW-1:0]   tail_d [LEVELS];
  logic [LEVELS-1:0] nonempty_q, nonempty_d;
  logic [Depth-1:0]  queued_q, queued_d;

  rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;

  logic [LV_W-1:0]   lv_sel;
  logic              any_ne;
  logic [IdxW-1:0]   head_sel;
  logic [IdxW-1:0]   tid_idx;
  logic              in_range;
  logic [IdxW-1:0]   prio_raddr;
  logic [PRIO_W-1:0] prio_rdata;
  logic [IdxW-1:0]   link_rdata;
  logic              prio_we, link_we;
  logic [IdxW-1:0]   prio_waddr, link_waddr;
  logic [PRIO_W-1:0] prio_wdata;
  logic [IdxW-1:0]   link_wdata;
  logic [PRIO_W-1:0] new_prio;
  logic [LV_W-1:0]   enq_lv;

  always_comb begin
    if (nonempty_q[2]) begin
      lv_sel = 2'd2;
    end else if (nonempty_q[1]) begin
      lv_sel = 2'd1;
    end else begin
      lv_sel = 2'd0;
    end
  end

  assign any_ne     = |nonempty_q;
  assign head_sel   = head_q[lv_sel];
  assign tid_idx    = tid_q[IdxW-1:0];
  assign in_range   = 32'(tid_q) < MAX_THREADS;
  assign prio_raddr = (cmd_e'(req_i.cmd) == CMD_DEQUEUE) ? head_sel
                                                          : req_i.thread_id[IdxW-1:0];

  frq_ram #(.Width(PRIO_W), .Depth(Depth)) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (prio_waddr),
    .wdata_i (prio_wdata),
    .re_i    (ctrl_i.load),
    .raddr_i (prio_raddr),
    .rdata_o (prio_rdata)
  );

  frq_ram #(.Width(IdxW), .Depth(Depth)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (ctrl_i.load),
    .raddr_i (head_sel),
    .rdata_o (link_rdata)
  );

  always_comb begin
    new_prio = prio_rdata;
    case (cmd_q)
      CMD_CREATE: begin
        if (plev_q == PRIO_HIGH) begin
          new_prio = PRIO_HIGH;
        end else if (plev_q == PRIO_MED) begin
          new_prio = PRIO_MED;
        end else begin
          new_prio = PRIO_LOW;
        end
      end
      CMD_ADJUST: begin
        if (used_q < quantum_i) begin
          if (prio_rdata != PRIO_HIGH) begin
            new_prio = prio_rdata + 2'd1;
          end
        end else if (prio_rdata != PRIO_LOW) begin
          new_prio = prio_rdata - 2'd1;
        end
      end
      default: new_prio = prio_rdata;
    endcase
  end

  assign enq_lv = (prio_rdata == PRIO_HIGH) ? 2'd2 :
                  (prio_rdata == PRIO_MED)  ? 2'd1 : 2'd0;

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    nonempty_d  = nonempty_q;
    queued_d    = queued_q;
    prio_we     = 1'b0;
    prio_waddr  = tid_idx;
    prio_wdata  = new_prio;
    link_we     = 1'b0;
    link_waddr  = tail_q[enq_lv];
    link_wdata  = tid_idx;
    rsp_d       = '{result_thread: tid_q, result_priority: '0,
                    previous_priority: '0, changed: 1'b0, status: 1'b0};
    if (ctrl_i.commit) begin
      if (cmd_q == CMD_DEQUEUE) begin
        if (any_ne) begin
          if (tail_q[lv_sel] == head_sel) begin
            nonempty_d[lv_sel] = 1'b0;
          end else begin
            head_d[lv_sel] = link_rdata;
          end
          queued_d[head_sel]      = 1'b0;
          rsp_d.result_thread     = TID_W'(head_sel);
          rsp_d.result_priority   = prio_rdata;
          rsp_d.previous_priority = prio_rdata;
        end else begin
          rsp_d.result_thread = '0;
          rsp_d.status        = 1'b1;
        end
      end else if (in_range) begin
        case (cmd_q)
          CMD_CREATE, CMD_ADJUST: begin
            prio_we                 = 1'b1;
            rsp_d.result_priority   = new_prio;
            rsp_d.previous_priority = (cmd_q == CMD_ADJUST) ? prio_rdata : new_prio;
            rsp_d.changed           = (cmd_q == CMD_ADJUST) && (new_prio != prio_rdata);
          end
          CMD_ENQUEUE: begin
            if (!queued_q[tid_idx]) begin
              if (nonempty_q[enq_lv]) begin
                link_we = 1'b1;
              end else begin
                head_d[enq_lv]     = tid_idx;
                nonempty_d[enq_lv] = 1'b1;
              end
              tail_d[enq_lv]    = tid_idx;
              queued_d[tid_idx] = 1'b1;
            end
            rsp_d.result_priority   = prio_rdata;
            rsp_d.previous_priority = prio_rdata;
          end
          default: rsp_d.status = 1'b0;
        endcase
      end
    end
  end

  assign rsp_valid_d = ctrl_i.commit || (rsp_valid_q && !rsp_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q  <= '0;
      queued_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      nonempty_q  <= nonempty_d;
      queued_q    <= queued_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
    if (ctrl_i.load) begin
      cmd_q  <= cmd_e'(req_i.cmd);
      tid_q  <= req_i.thread_id;
      plev_q <= req_i.priority_level;
      used_q <= req_i.time_used;
    end
    if (ctrl_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o            = rsp_q;
  assign stat_o.rsp_valid = rsp_valid_q;

endmodule

// ===== src/feedback_priority_ready_queue_top.sv =====
// ----------------------------------------------------------------------------
// feedback_priority_ready_queue_top
// Three-level ready queue of thread ids with feedback priority adjust.
// ----------------------------------------------------------------------------
// Commands arrive on req_i (create, enqueue, dequeue, adjust) and each one
// produces exactly one result transaction on rsp_o.
// A command first does the registered read of the priority and link RAMs,
// then updates the level head/tail state, writes back and loads the
// result register. The block holds one command at a time, so it does not
// accept a new command until the last one has loaded its result.
// The result sits in an output register; while the receiver stalls, the
// next command can still be accepted and read, and it waits in the
// execute cycle until the output register frees up.
// The time quantum is written over the APB port at byte address 0.
// Reset empties all three levels, clears every queued flag and sets the
// quantum to 10. Thread priorities and links are unknown until written.
// ----------------------------------------------------------------------------
module feedback_priority_ready_queue_top #(
  parameter int MAX_THREADS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  frq_req_if.sink                          req_i,
  frq_rsp_if.source                        rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [frq_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import frq_pkg::*;

  ctrl_t             ctrl;
  stat_t             stat;
  logic [USED_W-1:0] quantum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_QUANTUM)) begin
      quantum_q <= pwdata[USED_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUANTUM) ? 32'(quantum_q) : '0;

  frq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  frq_datapath #(.MAX_THREADS(MAX_THREADS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .req_i       (req_i.payload),
    .quantum_i   (quantum_q),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.payload),
    .stat_o      (stat)
  );

  assign rsp_o.valid = stat.rsp_valid;

endmodule

// ===== src/frq_checker.sv =====
// ----------------------------------------------------------------------------
// frq_checker
// Port-level checks on the ready queue, bound to the top level.
// ----------------------------------------------------------------------------
module frq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input frq_pkg::rsp_t rsp_i
);
  import frq_pkg::*;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_i))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("command accepted while another is in flight");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.status |->
      rsp_i.result_thread == '0 && rsp_i.result_priority == PRIO_LOW &&
      rsp_i.previous_priority == PRIO_LOW && !rsp_i.changed)
    else $error("empty dequeue result carries data");

  a_changed_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.changed |->
      rsp_i.result_priority != rsp_i.previous_priority && !rsp_i.status)
    else $error("changed flag without a priority change");

endmodule

bind feedback_priority_ready_queue_top frq_checker u_frq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);

// ===== bench/feedback_priority_ready_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// feedback_priority_ready_queue_top_test
// Self-checking bench for the three-level feedback priority ready queue. A
// directed table covers the empty dequeue, saturating adjusts, duplicate
// enqueues, create of a queued thread and priority code three. Randomized
// command phases follow under several quantum settings. Every result
// transaction is checked against the expected result given in the table or
// else a scoreboard model of the levels, links and priorities, with random
// gaps on both channels, a long receiver hold-off and a phase with no gaps.
// ----------------------------------------------------------------------------
module feedback_priority_ready_queue_top_test;
  import frq_pkg::*;

  localparam int PERIOD          = 8;
  localparam int NUM_PHASES      = 6;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_CYCLES     = 300;
  localparam int LIMIT           = 500000;
  localparam logic [APB_ADDR_W-1:0] QUANTUM_ADDR = APB_ADDR_W'(4 * REG_QUANTUM);

  typedef struct {
    cmd_e              cmd;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] plev;
    logic [USED_W-1:0] used;
    bit                known;
    rsp_t              want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frq_req_if req_if ();
  frq_rsp_if rsp_if ();

  feedback_priority_ready_queue_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // scoreboard copy of the ready queue
  logic [PRIO_W-1:0] prio_of  [ID_SPAN];
  logic [TID_W-1:0]  succ     [ID_SPAN];
  bit                queued   [ID_SPAN];
  bit                created  [ID_SPAN];
  logic [TID_W-1:0]  lvl_head [LEVELS];
  logic [TID_W-1:0]  lvl_tail [LEVELS];
  bit                lvl_busy [LEVELS];
  logic [USED_W-1:0] quantum;

  rsp_t      outcome_q [$];
  stim_row_t dir_tab [$];
  bit        quiet = 1'b0;
  int        hold_asked = 0;
  int        mismatches = 0;
  int        n_cmds = 0;
  int        n_checked = 0;
  int        n_empty = 0;
  int        n_changed = 0;
  int        cycle_cnt = 0;

  function automatic rsp_t rsp(int th, int cur, int prev, int chg, int st);
    rsp_t r;
    r.result_thread     = TID_W'(th);
    r.result_priority   = PRIO_W'(cur);
    r.previous_priority = PRIO_W'(prev);
    r.changed           = chg[0];
    r.status            = st[0];
    return r;
  endfunction

  function automatic void add_row(cmd_e c, int tid, int pl, int used, bit known = 1'b0,
                                  rsp_t want = '0);
    stim_row_t row;
    row.cmd   = c;
    row.tid   = TID_W'(tid);
    row.plev  = PRIO_W'(pl);
    row.used  = USED_W'(used);
    row.known = known;
    row.want  = want;
    dir_tab.push_back(row);
  endfunction

  function automatic rsp_t queue_outcome(req_t rq);
    rsp_t              r;
    logic [TID_W-1:0]  t;
    logic [TID_W-1:0]  h;
    logic [PRIO_W-1:0] old_p;
    logic [PRIO_W-1:0] now_p;
    int                lv;
    r = '0;
    t = rq.thread_id;
    case (rq.cmd)
      CMD_DEQUEUE: begin
        r.status = 1'b1;
        for (lv = LEVELS - 1; lv >= 0; lv--) begin
          if (lvl_busy[lv] && r.status) begin
            h = lvl_head[lv];
            if (lvl_tail[lv] == h) lvl_busy[lv] = 1'b0;
            else lvl_head[lv] = succ[h];
            queued[h] = 1'b0;
            r = rsp(h, prio_of[h], prio_of[h], 0, 0);
          end
        end
      end
      CMD_CREATE: begin
        if (rq.priority_level == PRIO_HIGH) prio_of[t] = PRIO_HIGH;
        else if (rq.priority_level == PRIO_MED) prio_of[t] = PRIO_MED;
        else prio_of[t] = PRIO_LOW;
        created[t] = 1'b1;
        r = rsp(t, prio_of[t], prio_of[t], 0, 0);
      end
      CMD_ENQUEUE: begin
        if (!queued[t]) begin
          lv = prio_of[t];
          if (lvl_busy[lv]) succ[lvl_tail[lv]] = t;
          else begin
            lvl_head[lv] = t;
            lvl_busy[lv] = 1'b1;
          end
          lvl_tail[lv] = t;
          succ[t]      = t;
          queued[t]    = 1'b1;
        end
        r = rsp(t, prio_of[t], prio_of[t], 0, 0);
      end
      default: begin
        old_p = prio_of[t];
        now_p = old_p;
        if (rq.time_used < quantum) begin
          if (old_p != PRIO_HIGH) now_p = old_p + 1'b1;
        end else if (old_p != PRIO_LOW) begin
          now_p = old_p - 1'b1;
        end
        prio_of[t] = now_p;
        r = rsp(t, now_p, old_p, (now_p != old_p) ? 1 : 0, 0);
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // enqueue/adjust only threads that hold a priority
  function automatic req_t random_request();
    req_t             rq;
    int               r;
    logic [TID_W-1:0] t;
    t = ($urandom_range(0, 3) == 0) ? TID_W'($urandom_range(0, ID_SPAN - 1))
                                    : TID_W'($urandom_range(0, 15));
    rq.thread_id      = t;
    rq.priority_level = PRIO_W'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       rq.time_used = quantum - 1'b1;
      1:       rq.time_used = quantum;
      2:       rq.time_used = $urandom_range(0, 1) ? '1 : '0;
      default: rq.time_used = USED_W'($urandom_range(0, 65535));
    endcase
    r = $urandom_range(0, 99);
    if (r < 15 || !created[t]) rq.cmd = CMD_CREATE;
    else if (r < 50) rq.cmd = CMD_ENQUEUE;
    else if (r < 80) rq.cmd = CMD_DEQUEUE;
    else rq.cmd = CMD_ADJUST;
    return rq;
  endfunction

  task automatic issue(input req_t rq, input bit known, input rsp_t want);
    int   gap;
    rsp_t got;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= rq;
    do @(posedge clk_i); while (!req_if.ready);
    got = queue_outcome(rq);
    outcome_q.push_back(known ? want : got);
    n_cmds++;
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == QUANTUM_ADDR) quantum = data[USED_W-1:0];
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (outcome_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $time, got);
      mismatches++;
    end else begin
      want = outcome_q.pop_front();
      compare_field("result_thread", want.result_thread, got.result_thread);
      compare_field("result_priority", want.result_priority, got.result_priority);
      compare_field("previous_priority", want.previous_priority, got.previous_priority);
      compare_field("changed", want.changed, got.changed);
      compare_field("status", want.status, got.status);
      n_checked++;
      if (want.status) n_empty++;
      if (want.changed) n_changed++;
    end
  endtask

  initial begin : rsp_side
    int stall_left;
    int hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) check_result(rsp_if.payload);
      if (hold_seen != hold_asked) begin
        hold_seen  = hold_asked;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("** feedback_priority_ready_queue_top: FAILED **");
    $finish;
  end

  initial begin : main_seq
    logic [USED_W-1:0] phase_q [NUM_PHASES];
    req_t              rq;
    int                ph;
    int                n;
    rst_ni         <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.payload <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    for (n = 0; n < ID_SPAN; n++) begin
      prio_of[n] = PRIO_LOW;
      succ[n]    = '0;
      queued[n]  = 1'b0;
      created[n] = 1'b0;
    end
    for (n = 0; n < LEVELS; n++) begin
      lvl_head[n] = '0;
      lvl_tail[n] = '0;
      lvl_busy[n] = 1'b0;
    end
    quantum = QUANTUM_RESET;

    add_row(CMD_DEQUEUE, 0, 0, 0, 1, rsp(0, 0, 0, 0, 1));
    add_row(CMD_CREATE, 0, 2, 0, 1, rsp(0, 2, 2, 0, 0));
    add_row(CMD_CREATE, 63, 0, 65535, 1, rsp(63, 0, 0, 0, 0));
    add_row(CMD_CREATE, 5, 3, 0, 1, rsp(5, 0, 0, 0, 0));
    add_row(CMD_CREATE, 7, 1, 0, 1, rsp(7, 1, 1, 0, 0));
    add_row(CMD_ENQUEUE, 63, 3, 65535, 1, rsp(63, 0, 0, 0, 0));
    add_row(CMD_ENQUEUE, 7, 0, 0);
    add_row(CMD_ENQUEUE, 0, 0, 0);
    add_row(CMD_ENQUEUE, 0, 0, 0, 1, rsp(0, 2, 2, 0, 0));
    add_row(CMD_ADJUST, 0, 0, 0, 1, rsp(0, 2, 2, 0, 0));
    add_row(CMD_ADJUST, 63, 0, 65535, 1, rsp(63, 0, 0, 0, 0));
    add_row(CMD_ADJUST, 7, 0, 9, 1, rsp(7, 2, 1, 1, 0));
    add_row(CMD_ADJUST, 7, 0, 10, 1, rsp(7, 1, 2, 1, 0));
    add_row(CMD_CREATE, 63, 2, 0, 1, rsp(63, 2, 2, 0, 0));
    add_row(CMD_ENQUEUE, 5, 0, 0);
    add_row(CMD_DEQUEUE, 0, 0, 0, 1, rsp(0, 2, 2, 0, 0));
    add_row(CMD_DEQUEUE, 0, 0, 0);
    add_row(CMD_DEQUEUE, 0, 0, 0);
    add_row(CMD_DEQUEUE, 0, 0, 0);
    add_row(CMD_DEQUEUE, 63, 3, 65535, 1, rsp(0, 0, 0, 0, 1));
    add_row(CMD_ENQUEUE, 5, 0, 0);
    add_row(CMD_ADJUST, 5, 0, 65535);
    add_row(CMD_DEQUEUE, 0, 0, 0);

    phase_q[0] = 16'd1;
    phase_q[1] = 16'd65535;
    phase_q[2] = 16'd0;
    phase_q[3] = USED_W'($urandom_range(1, 65535));
    phase_q[4] = QUANTUM_RESET;
    phase_q[5] = USED_W'($urandom_range(1, 40));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      rq.cmd            = dir_tab[i].cmd;
      rq.thread_id      = dir_tab[i].tid;
      rq.priority_level = dir_tab[i].plev;
      rq.time_used      = dir_tab[i].used;
      issue(rq, dir_tab[i].known, dir_tab[i].want);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      apb_write(QUANTUM_ADDR, 32'(phase_q[ph]));
      quiet = (ph == 1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // hold the receiver off while commands keep coming
        if (ph == 2 && n == 20) hold_asked++;
        if (ph == 3 && n == 75) drain_results();
        issue(random_request(), 1'b0, '0);
      end
    end
    quiet = 1'b0;
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d commands, checked %0d results: %0d empty dequeues, %0d priority changes,",
             n_cmds, n_checked, n_empty, n_changed);
    $display("quantum settings 10, 1, 65535, 0 and random, with receiver hold-off and no-gap phase");
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("** feedback_priority_ready_queue_top: PASSED **");
    end else begin
      $display("** feedback_priority_ready_queue_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== feedback_priority_ready_queue_top.f =====
src/frq_pkg.sv
src/frq_if.sv
src/frq_ram.sv
src/frq_ctrl.sv
src/frq_datapath.sv
src/feedback_priority_ready_queue_top.sv
src/frq_checker.sv
bench/feedback_priority_ready_queue_top_test.sv
